@@ sv/unique_train_index_match_filter_top_assert.svh @@
// Assertion macros for the filter RTL.
`ifndef UNIQUE_TRAIN_INDEX_MATCH_FILTER_TOP_ASSERT_SVH
`define UNIQUE_TRAIN_INDEX_MATCH_FILTER_TOP_ASSERT_SVH

// Checked outside reset.
`define UTIMF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define UTIMF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ sv/utimf_pkg.sv @@
`default_nettype none
package utimf_pkg;

  localparam int TRAIN_SLOTS = 4096;
  localparam int ADDR_W      = $clog2(TRAIN_SLOTS);
  localparam int TRAIN_W     = 12;
  localparam int QUERY_W     = 16;
  localparam int CNT_W       = 2;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_COUNT  = 2'd0,
    REQ_FILTER = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_kind_t;

  localparam logic [CNT_W-1:0] CNT_ZERO = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_SAT  = 2'd2;

  typedef struct packed {
    logic                is_count;
    logic                is_filter;
    logic                is_clear;
    logic                slot_ok;
    logic [TRAIN_W-1:0]  train;
    logic [QUERY_W-1:0]  query;
  } req_t;

endpackage
`default_nettype wire

@@ sv/utimf_if.sv @@
`default_nettype none
interface utimf_in_if;
  import utimf_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         req_type;
  logic [TRAIN_W-1:0] train_idx;
  logic [QUERY_W-1:0] query_idx;

  modport source (output valid, output req_type, output train_idx, output query_idx,
                  input ready);
  modport sink   (input valid, input req_type, input train_idx, input query_idx,
                  output ready);
endinterface

interface utimf_out_if;
  import utimf_pkg::*;
  logic               valid;
  logic               ready;
  logic               keep;
  logic [CNT_W-1:0]   seen_count;
  logic [TRAIN_W-1:0] match_train;
  logic [QUERY_W-1:0] match_query;

  modport source (output valid, output keep, output seen_count, output match_train,
                  output match_query, input ready);
  modport sink   (input valid, input keep, input seen_count, input match_train,
                  input match_query, output ready);
endinterface
`default_nettype wire

@@ sv/unique_train_index_match_filter_top.sv @@
// An item passes the queue, the read stage and the output register; output stall holds it.
// Throughput: one count or filter item per cycle if the output is not stalled; the table
// read-modify-write forwards the last write; back-to-back hits on one index do not stall.
// A clear item yields its result at once, then a clearing pass writes TRAIN_SLOTS entries
// during which no item is accepted.
// Reset: synchronous active-low rst_n; the same clearing pass follows reset.
`default_nettype none
module unique_train_index_match_filter_top import utimf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  utimf_in_if.sink    in_ch,
  utimf_out_if.source out_ch
);

  req_t push_item, pop_item;
  logic push, push_ready, pop, pop_valid, busy;

  utimf_front u_front (
    .in_ch   (in_ch),
    .busy    (busy),
    .q_ready (push_ready),
    .q_push  (push),
    .q_item  (push_item)
  );

  utimf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item)
  );

  utimf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_pop   (pop),
    .busy    (busy),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire

@@ sv/utimf_front.sv @@
`default_nettype none
module utimf_front import utimf_pkg::*; (
  utimf_in_if.sink in_ch,
  input  logic     busy,
  input  logic     q_ready,
  output logic     q_push,
  output req_t     q_item
);

  assign in_ch.ready = q_ready && !busy;
  assign q_push      = in_ch.valid && in_ch.ready;

  always_comb begin
    q_item           = '0;
    q_item.train     = in_ch.train_idx;
    q_item.query     = in_ch.query_idx;
    q_item.slot_ok   = (32'(in_ch.train_idx) < TRAIN_SLOTS);
    case (in_ch.req_type)
      REQ_COUNT:  q_item.is_count  = 1'b1;
      REQ_FILTER: q_item.is_filter = 1'b1;
      REQ_CLEAR:  q_item.is_clear  = 1'b1;
      default:    ;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/utimf_queue.sv @@
`default_nettype none
module utimf_queue import utimf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_item,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output req_t pop_item
);

  req_t              slots_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign push_ready = (cnt_r < QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = slots_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/utimf_back.sv @@
`default_nettype none
module utimf_back import utimf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  req_t      q_item,
  output logic      q_pop,
  output logic      busy,
  utimf_out_if.source out_ch
);

`include "unique_train_index_match_filter_top_assert.svh"

  logic [CNT_W-1:0]   mem [TRAIN_SLOTS];

  logic               clearing_r;
  logic [ADDR_W-1:0]  sweep_ptr_r;
  logic               a_valid_r;
  req_t               a_r;
  logic [CNT_W-1:0]   rdata_r;
  logic               byp_valid_r;
  logic [ADDR_W-1:0]  byp_addr_r;
  logic [CNT_W-1:0]   byp_data_r;
  logic               out_valid_r;
  logic               keep_r;
  logic [CNT_W-1:0]   seen_r;
  logic [TRAIN_W-1:0] train_r;
  logic [QUERY_W-1:0] query_r;

  logic [ADDR_W-1:0]  a_addr, q_addr, waddr;
  logic [CNT_W-1:0]   cur, inc, wdata, seen_nxt;
  logic               out_free, adv, load_a, wb_en, we, keep_nxt;

  assign a_addr   = ADDR_W'(a_r.train);
  assign q_addr   = ADDR_W'(q_item.train);
  assign out_free = !out_valid_r || out_ch.ready;
  assign adv      = a_valid_r && out_free;
  assign load_a   = (!a_valid_r || adv) && q_valid && !clearing_r && !(adv && a_r.is_clear);
  assign q_pop    = load_a;
  assign busy     = clearing_r;

  assign cur   = (byp_valid_r && byp_addr_r == a_addr) ? byp_data_r : rdata_r;
  assign inc   = (cur >= CNT_SAT) ? CNT_SAT : cur + CNT_ONE;
  assign wb_en = adv && a_r.is_count && a_r.slot_ok;
  assign we    = clearing_r || wb_en;
  assign waddr = clearing_r ? sweep_ptr_r : a_addr;
  assign wdata = clearing_r ? CNT_ZERO : inc;

  always_comb begin
    keep_nxt = 1'b0;
    seen_nxt = CNT_ZERO;
    if (a_r.slot_ok && a_r.is_count) begin
      seen_nxt = inc;
    end else if (a_r.slot_ok && a_r.is_filter) begin
      seen_nxt = cur;
      keep_nxt = (cur == CNT_ONE);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (load_a) begin
      rdata_r <= mem[q_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) a_r <= q_item;
    if (adv) begin
      keep_r  <= keep_nxt;
      seen_r  <= seen_nxt;
      train_r <= a_r.train;
      query_r <= a_r.query;
    end
    if (wb_en) begin
      byp_addr_r <= a_addr;
      byp_data_r <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      sweep_ptr_r <= '0;
      a_valid_r   <= 1'b0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        sweep_ptr_r <= sweep_ptr_r + ADDR_W'(1);
        if (sweep_ptr_r == ADDR_W'(TRAIN_SLOTS - 1)) begin
          clearing_r <= 1'b0;
        end
      end else if (adv && a_r.is_clear) begin
        clearing_r  <= 1'b1;
        sweep_ptr_r <= '0;
      end

      if (adv && a_r.is_clear) byp_valid_r <= 1'b0;
      else if (wb_en)          byp_valid_r <= 1'b1;

      if (load_a)   a_valid_r <= 1'b1;
      else if (adv) a_valid_r <= 1'b0;

      if (adv)               out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.keep        = keep_r;
  assign out_ch.seen_count  = seen_r;
  assign out_ch.match_train = train_r;
  assign out_ch.match_query = query_r;

  `UTIMF_ASSERT_ALWAYS(a_reset_sweeps, !rst_n |=> clearing_r && sweep_ptr_r == '0, "no sweep after reset")
  `UTIMF_ASSERT(a_no_read_in_sweep, clearing_r |-> !load_a, "table read during clearing pass")
  `UTIMF_ASSERT(a_one_writer, !(clearing_r && wb_en), "sweep and writeback collide")
  `UTIMF_ASSERT(a_clear_starts, adv && a_r.is_clear |=> clearing_r && sweep_ptr_r == '0, "clear did not start sweep")
  `UTIMF_ASSERT(a_keep_once, out_valid_r && keep_r |-> seen_r == CNT_ONE, "kept item without single count")

endmodule
`default_nettype wire
